@@ rtl/core/card_number_luhn_brand_check_unit_assert.svh @@
// Assertion macros used by the card number check checker file.
`ifndef CARD_NUMBER_LUHN_BRAND_CHECK_UNIT_ASSERT_SVH
`define CARD_NUMBER_LUHN_BRAND_CHECK_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while rst is high.
`define CNLBC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cnlbc: same-cycle property violated");

// Next-cycle implication, sampled on clk, quiet while rst is high.
`define CNLBC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cnlbc: next-cycle property violated");

`endif

@@ rtl/core/cnlbc_pkg.sv @@
// Shared constants, types and brand decode for the card number check unit.
`default_nettype none
package cnlbc_pkg;

  parameter int unsigned CARD_W         = 63;
  parameter int unsigned NUM_DIGITS     = 19;
  parameter int unsigned BCD_W          = 4 * NUM_DIGITS;
  parameter int unsigned CNT_W          = 5;
  parameter int unsigned BIT_CNT_W      = $clog2(CARD_W);
  parameter int unsigned IDX_W          = $clog2(NUM_DIGITS);
  parameter int unsigned MAX_DIGITS_DEF = 19;

  // Decimal radix, Luhn fold for doubled digits and BCD add-three adjust
  parameter logic [4:0] RADIX      = 5'd10;
  parameter logic [4:0] DBL_FOLD   = 5'd9;
  parameter logic [3:0] DIGIT_ADJ  = 4'd3;
  parameter logic [3:0] DIGIT_HALF = 4'd5;

  // Valid card lengths
  parameter logic [CNT_W-1:0] LEN_SHORT = 5'd13;
  parameter logic [CNT_W-1:0] LEN_MID   = 5'd15;
  parameter logic [CNT_W-1:0] LEN_LONG  = 5'd16;

  // Prefix digits that name a brand
  parameter logic [3:0] AMEX_HI   = 4'd3;
  parameter logic [3:0] AMEX_LO_A = 4'd4;
  parameter logic [3:0] AMEX_LO_B = 4'd7;
  parameter logic [3:0] VISA_HI   = 4'd4;
  parameter logic [3:0] MC_HI     = 4'd5;
  parameter logic [3:0] MC_LO_MIN = 4'd1;
  parameter logic [3:0] MC_LO_MAX = 4'd5;

  typedef enum logic [1:0] {
    BRAND_NONE = 2'd0,
    BRAND_AMEX = 2'd1,
    BRAND_VISA = 2'd2,
    BRAND_MC   = 2'd3
  } brand_t;

  // Status of the binary-to-decimal converter
  typedef struct packed {
    logic busy;
    logic done;
  } conv_stat_t;

  // Result of the digit scan
  typedef struct packed {
    logic             done;
    brand_t           brand;
    logic             ok;
    logic [CNT_W-1:0] count;
  } scan_res_t;

  // Brand from the two leading digits
  function automatic brand_t brand_of(input logic [3:0] hi, input logic [3:0] lo);
    brand_t b;
    b = BRAND_NONE;
    if (hi == AMEX_HI && (lo == AMEX_LO_A || lo == AMEX_LO_B)) begin
      b = BRAND_AMEX;
    end else if (hi == VISA_HI) begin
      b = BRAND_VISA;
    end else if (hi == MC_HI && lo >= MC_LO_MIN && lo <= MC_LO_MAX) begin
      b = BRAND_MC;
    end
    return b;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/cnlbc_bin2bcd.sv @@
// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
`default_nettype none
module cnlbc_bin2bcd (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           load,
  input  wire logic [cnlbc_pkg::CARD_W-1:0]   card_number,
  output cnlbc_pkg::conv_stat_t               stat,
  output logic      [cnlbc_pkg::BCD_W-1:0]    bcd
);
  import cnlbc_pkg::*;

  logic [CARD_W-1:0]    bin;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic                 running;
  logic                 done;
  logic [BCD_W-1:0]     bcd_adj;

  // Add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= DIGIT_HALF) ? bcd[4*i +: 4] + DIGIT_ADJ
                                                       : bcd[4*i +: 4];
    end
  end

  // Control: run for one shift per input bit, then pulse done
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      bit_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (load) begin
        running <= 1'b1;
        bit_cnt <= '0;
      end else if (running) begin
        bit_cnt <= bit_cnt + BIT_CNT_W'(1);
        if (bit_cnt == BIT_CNT_W'(CARD_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift the binary word into the digit register
  always_ff @(posedge clk) begin
    if (load) begin
      bin <= card_number;
      bcd <= '0;
    end else if (running) begin
      bin <= {bin[CARD_W-2:0], 1'b0};
      bcd <= {bcd_adj[BCD_W-2:0], bin[CARD_W-1]};
    end
  end

  assign stat.busy = running | done;
  assign stat.done = done;

endmodule
`default_nettype wire

@@ rtl/core/cnlbc_digit_scan.sv @@
// Digit-serial Luhn accumulator, length counter and prefix capture.
`default_nettype none
module cnlbc_digit_scan #(
  parameter int unsigned MAX_DIGITS = cnlbc_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         load,
  input  wire logic [cnlbc_pkg::BCD_W-1:0]  bcd,
  output logic                              busy,
  output cnlbc_pkg::scan_res_t              res
);
  import cnlbc_pkg::*;

  logic [BCD_W-1:0] sr;
  logic [IDX_W-1:0] idx;
  logic             running;
  logic [3:0]       acc;
  logic [CNT_W-1:0] cnt;
  logic [3:0]       hi;
  logic [3:0]       lo;
  logic [3:0]       prev;
  logic             done;
  brand_t           brand;
  logic             ok;
  logic [CNT_W-1:0] count;

  logic [3:0]       dig;
  logic [4:0]       dbl;
  logic [3:0]       contrib;
  logic [4:0]       sum;
  logic [3:0]       acc_next;
  logic [CNT_W-1:0] cnt_next;
  logic [3:0]       hi_next;
  logic [3:0]       lo_next;
  logic             ok_next;

  // Fold the current digit into the running totals
  always_comb begin
    dig      = sr[3:0];
    dbl      = {dig, 1'b0};
    contrib  = idx[0] ? ((dbl > DBL_FOLD) ? 4'(dbl - DBL_FOLD) : dbl[3:0]) : dig;
    sum      = {1'b0, acc} + {1'b0, contrib};
    acc_next = (sum >= RADIX) ? 4'(sum - RADIX) : sum[3:0];
    cnt_next = (dig != 4'd0) ? CNT_W'(idx) + CNT_W'(1) : cnt;
    hi_next  = (dig != 4'd0) ? dig : hi;
    lo_next  = (dig != 4'd0) ? prev : lo;
    ok_next  = (cnt_next == LEN_SHORT || cnt_next == LEN_MID || cnt_next == LEN_LONG)
               && (acc_next == 4'd0);
  end

  // Control: one digit per cycle, least significant first
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      idx     <= '0;
    end else begin
      done <= 1'b0;
      if (load) begin
        running <= 1'b1;
        idx     <= '0;
      end else if (running) begin
        idx <= idx + IDX_W'(1);
        if (idx == IDX_W'(NUM_DIGITS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Datapath: advance the digit register and hold the totals
  always_ff @(posedge clk) begin
    if (load) begin
      sr   <= bcd;
      acc  <= '0;
      cnt  <= '0;
      hi   <= '0;
      lo   <= '0;
      prev <= '0;
    end else if (running) begin
      sr   <= {4'd0, sr[BCD_W-1:4]};
      acc  <= acc_next;
      cnt  <= cnt_next;
      hi   <= hi_next;
      lo   <= lo_next;
      prev <= dig;
      if (idx == IDX_W'(NUM_DIGITS - 1)) begin
        ok    <= ok_next;
        brand <= ok_next ? brand_of(hi_next, lo_next) : BRAND_NONE;
        count <= (cnt_next > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS) : cnt_next;
      end
    end
  end

  assign busy      = running;
  assign res.done  = done;
  assign res.brand = brand;
  assign res.ok    = ok;
  assign res.count = count;

endmodule
`default_nettype wire

@@ rtl/core/card_number_luhn_brand_check_unit.sv @@
// Top level of the card number check: decimal conversion, Luhn check, brand.
//
//   channel  | signals                                  | handshake
//   ---------+------------------------------------------+---------------------------
//   command  | start, busy, card_number                 | taken when start & !busy
//   result   | done, brand, checksum_ok, digit_count    | one-cycle strobe on done
//
// The strobe on done follows a taken transaction through bit-serial
// shift-and-add-three conversion, the converter's done pulse as handover and
// the digit scan. A new transaction is taken in the strobe cycle, not before
// it, so one number is in flight at a time. rst is synchronous and clears all
// control state; the result side has no back-pressure.
`default_nettype none
module card_number_luhn_brand_check_unit #(
  parameter int unsigned MAX_DIGITS = cnlbc_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [cnlbc_pkg::CARD_W-1:0]  card_number,
  output logic                               done,
  output logic [1:0]                         brand,
  output logic                               checksum_ok,
  output logic [cnlbc_pkg::CNT_W-1:0]        digit_count
);
  import cnlbc_pkg::*;

  conv_stat_t       conv_stat;
  logic [BCD_W-1:0] bcd;
  logic             scan_busy;
  scan_res_t        res;
  logic             accept;

  // Take a transaction only when both stages are free
  assign accept = start & ~busy;
  assign busy   = conv_stat.busy | scan_busy;

  cnlbc_bin2bcd u_conv (
    .clk         (clk),
    .rst         (rst),
    .load        (accept),
    .card_number (card_number),
    .stat        (conv_stat),
    .bcd         (bcd)
  );

  cnlbc_digit_scan #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_scan (
    .clk  (clk),
    .rst  (rst),
    .load (conv_stat.done),
    .bcd  (bcd),
    .busy (scan_busy),
    .res  (res)
  );

  // Present the registered result
  assign done        = res.done;
  assign brand       = res.brand;
  assign checksum_ok = res.ok;
  assign digit_count = res.count;

endmodule
`default_nettype wire

@@ rtl/core/cnlbc_checker.sv @@
// Port-level checker for the card number check unit, bound to the top level.
`default_nettype none
`include "card_number_luhn_brand_check_unit_assert.svh"
module cnlbc_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic                         done,
  input wire logic [1:0]                   brand,
  input wire logic                         checksum_ok,
  input wire logic [cnlbc_pkg::CNT_W-1:0]  digit_count
);
  import cnlbc_pkg::*;

  logic len_ok;

  // Reported length is one of the accepted card lengths
  assign len_ok = (digit_count == LEN_SHORT) || (digit_count == LEN_MID) ||
                  (digit_count == LEN_LONG);

  // Result strobe only once the unit is free again
  `CNLBC_ASSERT_IMP(a_done_idle, done, !busy)

  // A taken transaction keeps the unit busy
  `CNLBC_ASSERT_NXT(a_start_busy, start && !busy, busy)

  // A brand is reported only for a passing number
  `CNLBC_ASSERT_IMP(a_brand_ok, done && (brand != BRAND_NONE), checksum_ok)

  // A passing number has a valid length
  `CNLBC_ASSERT_IMP(a_len_ok, done && checksum_ok, len_ok)

endmodule

bind card_number_luhn_brand_check_unit cnlbc_checker u_cnlbc_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .brand       (brand),
  .checksum_ok (checksum_ok),
  .digit_count (digit_count)
);
`default_nettype wire
